// File: hw/rtl/hmt_pkg.sv
// hmt_pkg: shared types and constants of the hit-or-miss transform core
// request and result payloads, pixel classes, register indexes, element geometry
// no dependencies
package hmt_pkg;

    // structuring element geometry
    localparam int ELEMENT_SIZE    = 5;
    localparam int WIN_SIZE        = 2 * ELEMENT_SIZE - 1;
    localparam int MASK_W          = ELEMENT_SIZE * ELEMENT_SIZE;
    localparam int ORIGIN_W        = 3;
    localparam int SIZE_REG_W      = 11;
    localparam int CFG_DATA_W      = MASK_W;
    localparam int CFG_INDEX_W     = 3;
    localparam int JOB_QUEUE_DEPTH = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_MASK   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS_MASK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_OROW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_OCOL   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS_OROW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS_OCOL  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_IMG_WIDTH  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_IMG_HEIGHT = 3'd7;

    // request kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // pixel values
    localparam logic [7:0] PIXEL_FG = 8'd255;
    localparam logic [7:0] PIXEL_BG = 8'd0;

    // pixel classes held in the line buffer
    typedef enum logic [1:0] {
        CLS_NEITHER = 2'd0,
        CLS_FG      = 2'd1,
        CLS_BG      = 2'd2
    } hmt_cls_t;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel;
    } hmt_req_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       last;
    } hmt_rsp_t;

    // element settings seen by the evaluation side
    typedef struct packed {
        logic [MASK_W-1:0]   hit_mask;
        logic [MASK_W-1:0]   miss_mask;
        logic [ORIGIN_W-1:0] hit_orow;
        logic [ORIGIN_W-1:0] hit_ocol;
        logic [ORIGIN_W-1:0] miss_orow;
        logic [ORIGIN_W-1:0] miss_ocol;
    } hmt_elem_cfg_t;

endpackage

// File: hw/rtl/hmt_line_buf.sv
// hmt_line_buf: banked line buffer, one bank per row slot, 2-bit pixel classes
// one write port, all banks read at one common column with registered data
// depends on nothing
module hmt_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int ROW_SLOTS = 10,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int SW = $clog2(ROW_SLOTS)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [SW-1:0]                 wr_slot,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [1:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [ROW_SLOTS-1:0][1:0]     rd_data
);

    // one memory per row slot
    for (genvar b = 0; b < ROW_SLOTS; b++)
    begin : g_bank
        logic [1:0] mem [MAX_WIDTH];
        logic [1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_slot == SW'(b)))
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_reg <= mem[rd_addr];
            end
        end

        assign rd_data[b] = rd_reg;
    end

endmodule

// File: hw/rtl/hmt_job_queue.sv
// hmt_job_queue: small fifo of output positions between front and back
// depends on hmt_pkg for its depth
module hmt_job_queue #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);
    import hmt_pkg::*;

    localparam int PW = $clog2(JOB_QUEUE_DEPTH);
    localparam int NW = $clog2(JOB_QUEUE_DEPTH + 1);

    logic [JOB_QUEUE_DEPTH-1:0][DATA_W-1:0] entry_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full       = (count_reg == NW'(JOB_QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue overflow");
`endif

endmodule

// File: hw/rtl/hmt_front.sv
// hmt_front: takes requests, classifies pixels into the line buffer,
// tracks input and output raster positions and issues output jobs
// depends on hmt_pkg
module hmt_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ROW_SLOTS  = 10,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1),
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int SW = $clog2(ROW_SLOTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  hmt_pkg::hmt_req_t req,
    input  logic [CW-1:0]     width,
    input  logic [RW-1:0]     height,
    input  logic              pend_valid,
    input  logic [RW-1:0]     pend_row,
    output logic              wr_en,
    output logic [SW-1:0]     wr_slot,
    output logic [AW-1:0]     wr_addr,
    output logic [1:0]        wr_data,
    input  logic              job_full,
    output logic              job_push,
    output logic [RW-1:0]     job_row,
    output logic [CW-1:0]     job_col,
    output logic [SW-1:0]     job_slot,
    output logic              job_last
);
    import hmt_pkg::*;

    localparam int LIM = ROW_SLOTS - ELEMENT_SIZE;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(ROW_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [SW-1:0] in_slot_reg, in_slot_next;
    logic [RW-1:0] out_row_reg,  out_row_next;
    logic [CW-1:0] out_col_reg,  out_col_next;
    logic [SW-1:0] out_slot_reg, out_slot_next;
    logic          fid_reg,  fid_next;
    logic          hold_reg, hold_next;

    logic [RW-1:0] or1, ir1, ir2;
    logic [CW-1:0] oc1, ic1, ic2, oc3;
    logic [SW-1:0] os1, is1, is2;
    logic          fid1, fid2;
    logic          is_pixel, emit, last, accept, block;
    logic [RW:0]   nr_a, nr, h_m1;
    logic [CW:0]   nc_a, nc, w_m1;
    logic [RW-1:0] guard_row;
    logic [RW+3:0] lim_row;
    logic [1:0]    cls;

    // positions brought back inside the frame, then the pixel write
    always_comb
    begin
        or1  = out_row_reg;
        oc1  = out_col_reg;
        os1  = out_slot_reg;
        ir1  = in_row_reg;
        ic1  = in_col_reg;
        is1  = in_slot_reg;
        fid1 = fid_reg;
        if (oc1 >= width)
        begin
            oc1 = '0;
            or1 = or1 + 1'b1;
            os1 = slot_inc(os1);
        end
        if (or1 >= height)
        begin
            or1  = '0;
            oc1  = '0;
            os1  = '0;
            ir1  = '0;
            ic1  = '0;
            is1  = '0;
            fid1 = 1'b0;
        end
        if (!fid1)
        begin
            if (ic1 >= width)
            begin
                ic1 = '0;
                ir1 = ir1 + 1'b1;
                is1 = slot_inc(is1);
            end
            if (ir1 >= height)
            begin
                fid1 = 1'b1;
            end
        end

        is_pixel = (req.func == FUNC_PIXEL) && !fid1;
        ir2  = ir1;
        ic2  = ic1;
        is2  = is1;
        fid2 = fid1;
        if (is_pixel)
        begin
            ic2 = ic1 + 1'b1;
            if (ic2 >= width)
            begin
                ic2 = '0;
                ir2 = ir1 + 1'b1;
                is2 = slot_inc(is1);
                if (ir2 >= height)
                begin
                    fid2 = 1'b1;
                end
            end
        end

        // window readiness
        nr_a = {1'b0, or1} + (RW+1)'(ELEMENT_SIZE - 1);
        h_m1 = {1'b0, height} - 1'b1;
        nr   = (nr_a > h_m1) ? h_m1 : nr_a;
        nc_a = {1'b0, oc1} + (CW+1)'(ELEMENT_SIZE - 1);
        w_m1 = {1'b0, width} - 1'b1;
        nc   = (nc_a > w_m1) ? w_m1 : nc_a;
        emit = fid2 || ({1'b0, ir2} > nr) || (({1'b0, ir2} == nr) && ({1'b0, ic2} > nc));
        last = (or1 == height - 1'b1) && (oc1 == width - 1'b1);
        oc3  = oc1 + 1'b1;
    end

    // keep writes clear of line buffer rows the back still has to read
    always_comb
    begin
        guard_row = pend_valid ? pend_row : or1;
        lim_row   = (RW+4)'(guard_row) + (RW+4)'(LIM);
        block     = !fid1 && ((RW+4)'(ir1) > lim_row);
    end

    assign req_ready = !job_full && !(hold_reg && pend_valid) && !block;
    assign accept    = req_valid && req_ready;

    // pixel class
    always_comb
    begin
        if (req.pixel == PIXEL_FG)
        begin
            cls = CLS_FG;
        end
        else if (req.pixel == PIXEL_BG)
        begin
            cls = CLS_BG;
        end
        else
        begin
            cls = CLS_NEITHER;
        end
    end

    assign wr_en   = accept && is_pixel;
    assign wr_slot = is1;
    assign wr_addr = ic1[AW-1:0];
    assign wr_data = cls;

    assign job_push = accept && emit;
    assign job_row  = or1;
    assign job_col  = oc1;
    assign job_slot = os1;
    assign job_last = last;

    // next positions
    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        fid_next      = fid_reg;
        hold_next     = hold_reg;
        if (!pend_valid)
        begin
            hold_next = 1'b0;
        end
        if (accept)
        begin
            in_row_next   = ir2;
            in_col_next   = ic2;
            in_slot_next  = is2;
            fid_next      = fid2;
            out_row_next  = or1;
            out_col_next  = oc1;
            out_slot_next = os1;
            if (emit && last)
            begin
                in_row_next   = '0;
                in_col_next   = '0;
                in_slot_next  = '0;
                fid_next      = 1'b0;
                out_row_next  = '0;
                out_col_next  = '0;
                out_slot_next = '0;
                hold_next     = 1'b1;
            end
            else if (emit)
            begin
                if (oc3 >= width)
                begin
                    out_col_next  = '0;
                    out_row_next  = or1 + 1'b1;
                    out_slot_next = slot_inc(os1);
                end
                else
                begin
                    out_col_next = oc3;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            fid_reg      <= 1'b0;
            hold_reg     <= 1'b0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            fid_reg      <= fid_next;
            hold_reg     <= hold_next;
        end
    end

endmodule

// File: hw/rtl/hmt_back.sv
// hmt_back: reads line buffer columns into a sliding 9x9 class window,
// tests the hit and miss elements and holds the result register
// depends on hmt_pkg
module hmt_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ROW_SLOTS  = 10,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1),
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int SW = $clog2(ROW_SLOTS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hmt_pkg::hmt_elem_cfg_t    elem_cfg,
    input  logic [CW-1:0]             width,
    input  logic [RW-1:0]             height,
    input  logic                      job_valid,
    input  logic [RW-1:0]             job_row,
    input  logic [CW-1:0]             job_col,
    input  logic [SW-1:0]             job_slot,
    input  logic                      job_last,
    output logic                      job_pop,
    output logic                      busy,
    output logic [RW-1:0]             busy_row,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  logic [ROW_SLOTS-1:0][1:0] rd_data,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output hmt_pkg::hmt_rsp_t         rsp
);
    import hmt_pkg::*;

    localparam int STW = $clog2(ELEMENT_SIZE);
    localparam int HALF = ELEMENT_SIZE - 1;

    // issue stage
    logic          a_valid_reg;
    logic [RW-1:0] a_row_reg;
    logic [CW-1:0] a_col_reg;
    logic [SW-1:0] a_slot_reg;
    logic          a_last_reg;
    logic [STW-1:0] a_step_reg;
    logic          a_start, a_eval, a_clear;
    logic [CW:0]   a_colread;

    // read data stage
    logic          b_valid_reg;
    logic [RW-1:0] b_row_reg;
    logic [SW-1:0] b_slot_reg;
    logic [CW:0]   b_colread_reg;
    logic          b_clear_reg;
    logic          b_eval_reg;
    logic          b_last_reg;

    // window and evaluation stage
    logic [WIN_SIZE-1:0][WIN_SIZE-1:0][1:0] win_reg, win_next;
    logic          c_valid_reg;
    logic          c_last_reg;

    logic          out_valid_reg;
    hmt_rsp_t      out_reg;

    logic          adv;
    logic [WIN_SIZE-1:0][1:0] new_col;
    logic [WIN_SIZE-1:0][WIN_SIZE-1:0] hit_win, miss_win;
    logic          pass;

    assign adv = !out_valid_reg || rsp_ready;

    // column to read for the job in the issue stage
    always_comb
    begin
        a_start   = (a_col_reg == '0);
        a_colread = a_start ? (CW+1)'(a_step_reg)
                            : {1'b0, a_col_reg} + (CW+1)'(HALF);
        a_eval    = !a_start || (a_step_reg == STW'(HALF));
        a_clear   = a_start && (a_step_reg == '0);
    end

    assign job_pop  = adv && job_valid && (!a_valid_reg || a_eval);
    assign rd_en    = adv && a_valid_reg;
    assign rd_addr  = a_colread[AW-1:0];
    assign busy     = a_valid_reg;
    assign busy_row = a_row_reg;

    // issue stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_step_reg  <= '0;
        end
        else if (adv)
        begin
            if (a_valid_reg && !a_eval)
            begin
                a_step_reg <= a_step_reg + 1'b1;
            end
            else
            begin
                a_valid_reg <= job_valid;
                a_step_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            a_row_reg  <= job_row;
            a_col_reg  <= job_col;
            a_slot_reg <= job_slot;
            a_last_reg <= job_last;
        end
    end

    // valid flags of the read data, window and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg && b_eval_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_row_reg     <= a_row_reg;
            b_slot_reg    <= a_slot_reg;
            b_colread_reg <= a_colread;
            b_clear_reg   <= a_clear;
            b_eval_reg    <= a_eval;
            b_last_reg    <= a_last_reg;
            c_last_reg    <= b_last_reg;
            if (b_valid_reg)
            begin
                win_reg <= win_next;
            end
            if (c_valid_reg)
            begin
                out_reg.out_pixel <= pass ? PIXEL_FG : PIXEL_BG;
                out_reg.last      <= c_last_reg;
            end
        end
    end

    // new window column: rotate banks to row offsets, mask outside the frame
    always_comb
    begin
        logic signed [RW+1:0] rr;
        logic [SW+1:0]        bi;
        logic                 col_in;
        col_in = (b_colread_reg < {1'b0, width});
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            rr = $signed({2'b00, b_row_reg}) + (RW+2)'(i) - (RW+2)'(HALF);
            bi = (SW+2)'(b_slot_reg) + (SW+2)'(i) + (SW+2)'(ROW_SLOTS - HALF);
            if (bi >= (SW+2)'(ROW_SLOTS))
            begin
                bi = bi - (SW+2)'(ROW_SLOTS);
            end
            if (bi >= (SW+2)'(ROW_SLOTS))
            begin
                bi = bi - (SW+2)'(ROW_SLOTS);
            end
            if (col_in && (rr >= 0) && (rr < $signed({2'b00, height})))
            begin
                new_col[i] = rd_data[bi[SW-1:0]];
            end
            else
            begin
                new_col[i] = CLS_NEITHER;
            end
        end
    end

    // window shift, cleared at the start of an output row
    always_comb
    begin
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            for (int j = 0; j < WIN_SIZE - 1; j++)
            begin
                win_next[i][j] = b_clear_reg ? CLS_NEITHER : win_reg[i][j+1];
            end
            win_next[i][WIN_SIZE-1] = new_col[i];
        end
    end

    // elements placed into the window around their origins
    always_comb
    begin
        int hr, hc, mr, mc, k, l, hb, mb;
        hr = (int'(elem_cfg.hit_orow)  > HALF) ? HALF : int'(elem_cfg.hit_orow);
        hc = (int'(elem_cfg.hit_ocol)  > HALF) ? HALF : int'(elem_cfg.hit_ocol);
        mr = (int'(elem_cfg.miss_orow) > HALF) ? HALF : int'(elem_cfg.miss_orow);
        mc = (int'(elem_cfg.miss_ocol) > HALF) ? HALF : int'(elem_cfg.miss_ocol);
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                k = i + hr - HALF;
                l = j + hc - HALF;
                hb = ((k >= 0) && (k < ELEMENT_SIZE) && (l >= 0) && (l < ELEMENT_SIZE))
                     ? (k * ELEMENT_SIZE + l) : 0;
                hit_win[i][j] = (k >= 0) && (k < ELEMENT_SIZE) && (l >= 0) && (l < ELEMENT_SIZE)
                                && elem_cfg.hit_mask[hb];
                k = i + mr - HALF;
                l = j + mc - HALF;
                mb = ((k >= 0) && (k < ELEMENT_SIZE) && (l >= 0) && (l < ELEMENT_SIZE))
                     ? (k * ELEMENT_SIZE + l) : 0;
                miss_win[i][j] = (k >= 0) && (k < ELEMENT_SIZE) && (l >= 0) && (l < ELEMENT_SIZE)
                                 && elem_cfg.miss_mask[mb];
            end
        end
    end

    // both element tests over the window
    always_comb
    begin
        pass = 1'b1;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                if (hit_win[i][j] && (win_reg[i][j] != CLS_FG))
                begin
                    pass = 1'b0;
                end
                if (miss_win[i][j] && (win_reg[i][j] != CLS_BG))
                begin
                    pass = 1'b0;
                end
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef NO_ASSERTIONS
    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job taken from an empty queue");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_step_reg <= STW'(HALF)))
        else $error("row preload ran past the window");
    a_eval_held: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !adv) |=> c_valid_reg)
        else $error("evaluated window lost while the result is stalled");
`endif

endmodule

// File: hw/rtl/binary_hit_or_miss_transform_core.sv
// binary_hit_or_miss_transform_core: top level of the hit-or-miss transform
// holds the configuration registers and joins front, job queue, line buffer and back
// depends on hmt_pkg, hmt_front, hmt_job_queue, hmt_line_buf, hmt_back
//
// Streams a raster image in (one pixel request per cycle while req_ready
// is high) and returns the binary hit-or-miss transform in raster order,
// 255 where every hit cell lands on a 255 pixel and every miss cell on a 0
// pixel, else 0; drain requests flush the tail of the frame. The front takes
// one request per cycle while not stalled and writes pixel classes into
// ROW_SLOTS line buffer banks; the back reads one column of all banks per
// output into a 9x9 window, and at the start of every output row it first
// preloads the leading window columns. A four-entry job queue lets the two
// sides stall apart. After the last output job of a frame is issued, the next
// frame's first request waits until the back has read out the old frame.
// There is no clearing pass after reset.
module binary_hit_or_miss_transform_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ROW_SLOTS  = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [hmt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  hmt_pkg::hmt_req_t              req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output hmt_pkg::hmt_rsp_t              rsp
);
    import hmt_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int SW  = $clog2(ROW_SLOTS);
    localparam int SZW = ((CW > SIZE_REG_W) ? CW : SIZE_REG_W) + 1;
    localparam int SZH = ((RW > SIZE_REG_W) ? RW : SIZE_REG_W) + 1;
    localparam int JW  = RW + CW + SW + 1;

    hmt_elem_cfg_t           elem_reg;
    logic [SIZE_REG_W-1:0]   img_width_reg;
    logic [SIZE_REG_W-1:0]   img_height_reg;
    logic [CW-1:0]           eff_width;
    logic [RW-1:0]           eff_height;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg       <= '0;
            img_width_reg  <= SIZE_REG_W'(1024);
            img_height_reg <= SIZE_REG_W'(1024);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HIT_MASK:   elem_reg.hit_mask  <= cfg_data[MASK_W-1:0];
                REG_MISS_MASK:  elem_reg.miss_mask <= cfg_data[MASK_W-1:0];
                REG_HIT_OROW:   elem_reg.hit_orow  <= cfg_data[ORIGIN_W-1:0];
                REG_HIT_OCOL:   elem_reg.hit_ocol  <= cfg_data[ORIGIN_W-1:0];
                REG_MISS_OROW:  elem_reg.miss_orow <= cfg_data[ORIGIN_W-1:0];
                REG_MISS_OCOL:  elem_reg.miss_ocol <= cfg_data[ORIGIN_W-1:0];
                REG_IMG_WIDTH:  img_width_reg      <= cfg_data[SIZE_REG_W-1:0];
                REG_IMG_HEIGHT: img_height_reg     <= cfg_data[SIZE_REG_W-1:0];
                default:        elem_reg           <= elem_reg;
            endcase
        end
    end

    // frame size clamped to 1..max
    always_comb
    begin
        if (img_width_reg == '0)
        begin
            eff_width = CW'(1);
        end
        else if (SZW'(img_width_reg) > SZW'(MAX_WIDTH))
        begin
            eff_width = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = CW'(img_width_reg);
        end
        if (img_height_reg == '0)
        begin
            eff_height = RW'(1);
        end
        else if (SZH'(img_height_reg) > SZH'(MAX_HEIGHT))
        begin
            eff_height = RW'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = RW'(img_height_reg);
        end
    end

    logic          wr_en;
    logic [SW-1:0] wr_slot;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [ROW_SLOTS-1:0][1:0] rd_data;

    logic          job_push, job_full, job_pop, job_valid;
    logic [RW-1:0] push_row, head_row;
    logic [CW-1:0] push_col, head_col;
    logic [SW-1:0] push_slot, head_slot;
    logic          push_last, head_last;
    logic [JW-1:0] push_data, head_data;

    logic          back_busy;
    logic [RW-1:0] back_row;
    logic          pend_valid;
    logic [RW-1:0] pend_row;

    assign push_data = {push_row, push_col, push_slot, push_last};
    assign {head_row, head_col, head_slot, head_last} = head_data;

    // oldest output row whose window columns are still to be read
    assign pend_valid = back_busy || job_valid;
    assign pend_row   = back_busy ? back_row : head_row;

    hmt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_SLOTS  (ROW_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .width      (eff_width),
        .height     (eff_height),
        .pend_valid (pend_valid),
        .pend_row   (pend_row),
        .wr_en      (wr_en),
        .wr_slot    (wr_slot),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_full   (job_full),
        .job_push   (job_push),
        .job_row    (push_row),
        .job_col    (push_col),
        .job_slot   (push_slot),
        .job_last   (push_last)
    );

    hmt_job_queue #(
        .DATA_W (JW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (push_data),
        .full       (job_full),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_data  (head_data)
    );

    hmt_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ROW_SLOTS (ROW_SLOTS)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hmt_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_SLOTS  (ROW_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem_cfg  (elem_reg),
        .width     (eff_width),
        .height    (eff_height),
        .job_valid (job_valid),
        .job_row   (head_row),
        .job_col   (head_col),
        .job_slot  (head_slot),
        .job_last  (head_last),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .busy_row  (back_row),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
